@@ hw/rtl/grpm_pkg.sv @@
package grpm_pkg;

    localparam int CMD_W     = 2;
    localparam int SAMPLE_W  = 24;
    localparam int CHAN_W    = 5;
    localparam int KIND_W    = 2;
    localparam int IDX_W     = 6;
    localparam int PEAK_W    = 23;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int CCNT_W    = 6;
    localparam int FRAMES_W  = 16;
    localparam int TGT_W     = 17;
    localparam int GAIN_W    = 33;
    localparam int STEP_W    = 34;
    localparam int PLO_W     = 40;
    localparam int PHI_W     = 41;

    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int SEARCH_SPAN_DEF   = 128;
    localparam int TRACE_POINTS_DEF  = 64;
    localparam int MAX_CHANNELS      = 32;

    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEAK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRACE  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_CNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FRAMES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCOPE_EN    = 2'd3;

    localparam logic [TGT_W-1:0]    UNITY_Q16        = 17'h10000;
    localparam logic [PEAK_W-1:0]   PEAK_MAX         = 23'h7FFFFF;
    localparam logic [CCNT_W-1:0]   CHAN_CNT_RST     = 6'd2;
    localparam logic [FRAMES_W-1:0] RAMP_FRAMES_RST  = 16'd240;

    typedef struct packed {
        logic clr_wr;
        logic start_blk;
        logic div_start;
        logic div_take;
        logic take_sample;
        logic mul_lo;
        logic mul_hi;
        logic fin;
        logic emit_sample;
        logic emit_peak;
        logic srch_init;
        logic mem_rd;
        logic srch_step;
        logic tr_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic gain_chg;
        logic scope;
        logic div_busy;
        logic out_free;
        logic srch_first;
        logic srch_hit;
        logic srch_end;
        logic tr_last;
    } t_dp_stat;

endpackage

@@ hw/rtl/grpm_if.sv @@
interface grpm_in_if;
    import grpm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CHAN_W-1:0]          channel;

    modport source(output valid, cmd, sample_in, channel, input ready);
    modport sink(input valid, cmd, sample_in, channel, output ready);
endinterface

interface grpm_out_if;
    import grpm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] value;
    logic [IDX_W-1:0]           trace_index;
    logic [PEAK_W-1:0]          in_peak;
    logic [PEAK_W-1:0]          out_peak;
    logic                       last;

    modport source(output valid, kind, value, trace_index, in_peak, out_peak, last,
                   input ready);
    modport sink(input valid, kind, value, trace_index, in_peak, out_peak, last,
                 output ready);
endinterface

@@ hw/rtl/grpm_div.sv @@
module grpm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [grpm_pkg::GAIN_W-1:0]   i_dividend,
    input  logic [grpm_pkg::FRAMES_W-1:0] i_divisor,
    output logic                        o_busy,
    output logic [grpm_pkg::GAIN_W-1:0]   o_quot
);
    import grpm_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [FRAMES_W-1:0] r_rem;
    logic [GAIN_W-1:0]   r_q;
    logic [FRAMES_W-1:0] r_dvs;
    logic [FRAMES_W:0]   trial;
    logic                fits;

    // restoring division, one quotient bit per cycle; dividend shifts out of r_q
    assign trial = {r_rem, r_q[GAIN_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(GAIN_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? FRAMES_W'(trial - {1'b0, r_dvs}) : trial[FRAMES_W-1:0];
            r_q   <= {r_q[GAIN_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
endmodule

@@ hw/rtl/grpm_dp.sv @@
module grpm_dp #(
    parameter int HISTORY_DEPTH = grpm_pkg::HISTORY_DEPTH_DEF,
    parameter int SEARCH_SPAN   = grpm_pkg::SEARCH_SPAN_DEF,
    parameter int TRACE_POINTS  = grpm_pkg::TRACE_POINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  grpm_pkg::t_dp_cmd                  i_cmd,
    output grpm_pkg::t_dp_stat                 o_stat,
    input  logic                               i_cfg_we,
    input  logic [grpm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [grpm_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [grpm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [grpm_pkg::CHAN_W-1:0]        i_channel,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [grpm_pkg::KIND_W-1:0]        o_kind,
    output logic signed [grpm_pkg::SAMPLE_W-1:0] o_value,
    output logic [grpm_pkg::IDX_W-1:0]         o_trace_index,
    output logic [grpm_pkg::PEAK_W-1:0]        o_in_peak,
    output logic [grpm_pkg::PEAK_W-1:0]        o_out_peak,
    output logic                               o_last
);
    import grpm_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SW = $clog2(SEARCH_SPAN);

    // configuration
    logic [CCNT_W-1:0]   r_chan_cnt;
    logic [FRAMES_W-1:0] r_ramp_frames;
    logic [TGT_W-1:0]    r_target;
    logic                r_scope;

    // ramp and meter state
    logic [GAIN_W-1:0]        r_ramp_gain;
    logic signed [STEP_W-1:0] r_ramp_step;
    logic [FRAMES_W-1:0]      r_frames_left;
    logic [TGT_W-1:0]         r_latched;
    logic [PEAK_W-1:0]        r_in_peak;
    logic [PEAK_W-1:0]        r_out_peak;
    logic signed [SAMPLE_W-1:0] r_fe;
    logic [SAMPLE_W-1:0]      r_fe_mag;
    logic [AW-1:0]            r_pos;

    // per-sample working registers
    logic                     r_x_neg;
    logic [SAMPLE_W-1:0]      r_mx;
    logic [CHAN_W-1:0]        r_ch;
    logic [PLO_W-1:0]         r_plo;
    logic [PHI_W-1:0]         r_phi;
    logic [SAMPLE_W-1:0]      r_ymag;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                     r_neg;

    // history and walk
    logic signed [SAMPLE_W-1:0] mem [HISTORY_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd;
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [AW-1:0]            r_addr;
    logic [SW-1:0]            r_sidx;
    logic [IDX_W-1:0]         r_tidx;

    // output register
    logic                       r_out_valid;
    logic [KIND_W-1:0]          r_kind;
    logic signed [SAMPLE_W-1:0] r_value;
    logic [IDX_W-1:0]           r_tix;
    logic [PEAK_W-1:0]          r_oin;
    logic [PEAK_W-1:0]          r_oout;
    logic                       r_last;

    logic [TGT_W-1:0]         tgt_clamp;
    logic signed [STEP_W-1:0] diff;
    logic [GAIN_W-1:0]        diff_mag;
    logic [FRAMES_W-1:0]      len;
    logic                     div_busy;
    logic [GAIN_W-1:0]        quot;
    logic signed [STEP_W-1:0] gsum;
    logic [SAMPLE_W-1:0]      mx_in;
    logic [PHI_W:0]           psum;
    logic [PEAK_W-1:0]        mx_sat;
    logic [PEAK_W-1:0]        y_sat;
    logic signed [SAMPLE_W-1:0] fe_new;
    logic [SAMPLE_W-1:0]      fe_mag_new;
    logic [CCNT_W:0]          cnt;
    logic                     frame_end;
    logic [AW-1:0]            addr_inc;
    logic [AW:0]              addr_p2;
    logic [AW-1:0]            addr_inc2;
    logic [AW-1:0]            pos_inc;
    logic                     out_free;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;

    assign tgt_clamp = (r_target > UNITY_Q16) ? UNITY_Q16 : r_target;
    assign diff      = $signed({1'b0, tgt_clamp, 16'b0}) - $signed({1'b0, r_ramp_gain});
    assign diff_mag  = diff[STEP_W-1] ? GAIN_W'(-diff) : GAIN_W'(diff);
    assign len       = (r_ramp_frames == '0) ? FRAMES_W'(1) : r_ramp_frames;

    grpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (diff_mag),
        .i_divisor  (len),
        .o_busy     (div_busy),
        .o_quot     (quot)
    );

    assign gsum  = $signed({1'b0, r_ramp_gain}) + r_ramp_step;
    assign mx_in = i_sample[SAMPLE_W-1] ? SAMPLE_W'(-i_sample) : SAMPLE_W'(i_sample);

    // (mx*gain) >> 32 == (phi + (plo >> 16)) >> 16
    assign psum = (PHI_W+1)'(r_phi) + (PHI_W+1)'(r_plo[PLO_W-1:16]);

    assign mx_sat = r_mx[SAMPLE_W-1] ? PEAK_MAX : r_mx[PEAK_W-1:0];
    assign y_sat  = r_ymag[SAMPLE_W-1] ? PEAK_MAX : r_ymag[PEAK_W-1:0];

    always_comb begin
        if (r_scope && (r_ymag > r_fe_mag)) begin
            fe_new     = r_y;
            fe_mag_new = r_ymag;
        end else begin
            fe_new     = r_fe;
            fe_mag_new = r_fe_mag;
        end
        if (r_chan_cnt == '0) begin
            cnt = (CCNT_W+1)'(1);
        end else if ({1'b0, r_chan_cnt} > (CCNT_W+1)'(MAX_CHANNELS)) begin
            cnt = (CCNT_W+1)'(MAX_CHANNELS);
        end else begin
            cnt = {1'b0, r_chan_cnt};
        end
    end

    assign frame_end = ((CCNT_W+1)'(r_ch) + 1'b1) >= cnt;

    assign addr_inc  = (r_addr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_addr + 1'b1;
    assign addr_p2   = {1'b0, r_addr} + (AW+1)'(2);
    assign addr_inc2 = (addr_p2 >= (AW+1)'(HISTORY_DEPTH))
                     ? AW'(addr_p2 - (AW+1)'(HISTORY_DEPTH)) : addr_p2[AW-1:0];
    assign pos_inc   = (r_pos == AW'(HISTORY_DEPTH - 1)) ? '0 : r_pos + 1'b1;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt    <= CHAN_CNT_RST;
            r_ramp_frames <= RAMP_FRAMES_RST;
            r_target      <= UNITY_Q16;
            r_scope       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHAN_CNT:    r_chan_cnt    <= i_cfg_data[CCNT_W-1:0];
                CFG_RAMP_FRAMES: r_ramp_frames <= i_cfg_data[FRAMES_W-1:0];
                CFG_TARGET_GAIN: r_target      <= i_cfg_data[TGT_W-1:0];
                CFG_SCOPE_EN:    r_scope       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ramp, peaks, frame extreme, history pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_gain   <= {UNITY_Q16, 16'b0};
            r_ramp_step   <= '0;
            r_frames_left <= '0;
            r_latched     <= UNITY_Q16;
            r_in_peak     <= '0;
            r_out_peak    <= '0;
            r_fe          <= '0;
            r_fe_mag      <= '0;
            r_pos         <= '0;
        end else begin
            if (i_cmd.start_blk) begin
                r_in_peak  <= '0;
                r_out_peak <= '0;
                r_fe       <= '0;
                r_fe_mag   <= '0;
            end
            if (i_cmd.div_take) begin
                r_ramp_step   <= r_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
                r_frames_left <= len;
                r_latched     <= tgt_clamp;
            end
            if (i_cmd.take_sample && (i_channel == '0) && (r_frames_left != '0)) begin
                r_frames_left <= r_frames_left - 1'b1;
                if (r_frames_left == FRAMES_W'(1)) r_ramp_gain <= {r_latched, 16'b0};
                else                               r_ramp_gain <= gsum[GAIN_W-1:0];
            end
            if (i_cmd.emit_sample) begin
                if (mx_sat > r_in_peak) r_in_peak  <= mx_sat;
                if (y_sat > r_out_peak) r_out_peak <= y_sat;
                if (frame_end) begin
                    r_fe     <= '0;
                    r_fe_mag <= '0;
                    if (r_scope) r_pos <= pos_inc;
                end else begin
                    r_fe     <= fe_new;
                    r_fe_mag <= fe_mag_new;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) r_neg <= diff[STEP_W-1];
        if (i_cmd.take_sample) begin
            r_x_neg <= i_sample[SAMPLE_W-1];
            r_mx    <= mx_in;
            r_ch    <= i_channel;
        end
        if (i_cmd.mul_lo) r_plo <= r_mx * r_ramp_gain[15:0];
        if (i_cmd.mul_hi) r_phi <= r_mx * r_ramp_gain[GAIN_W-1:16];
        if (i_cmd.fin) begin
            r_ymag <= psum[SAMPLE_W+15:16];
            r_y    <= r_x_neg ? -$signed(psum[SAMPLE_W+15:16]) : $signed(psum[SAMPLE_W+15:16]);
        end
    end

    // history memory: one write port, one registered read port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_addr;
        wr_data = '0;
        if (i_cmd.clr_wr) begin
            wr_en = 1'b1;
        end else if (i_cmd.emit_sample && frame_end && r_scope) begin
            wr_en   = 1'b1;
            wr_addr = r_pos;
            wr_data = fe_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_cmd.mem_rd) r_rd <= mem[r_addr];
    end

    // walk address: clearing pass, zero-crossing search, trace readout
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_addr <= addr_inc;
        end else if (i_cmd.srch_init) begin
            r_addr <= r_pos;
        end else if (i_cmd.srch_step) begin
            if (r_sidx == '0) begin
                r_addr <= addr_inc;
            end else if (o_stat.srch_hit) begin
                r_addr <= r_addr;
            end else if (o_stat.srch_end) begin
                r_addr <= r_pos;
            end else begin
                r_addr <= addr_inc;
            end
        end else if (i_cmd.tr_load) begin
            r_addr <= addr_inc2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_sidx <= '0;
            r_tidx <= '0;
        end else if (i_cmd.srch_step) begin
            r_prev <= r_rd;
            r_sidx <= r_sidx + 1'b1;
        end else if (i_cmd.tr_load) begin
            r_tidx <= r_tidx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sample || i_cmd.emit_peak || i_cmd.tr_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sample) begin
            r_kind  <= KIND_SAMPLE;
            r_value <= r_y;
            r_tix   <= '0;
            r_oin   <= '0;
            r_oout  <= '0;
            r_last  <= 1'b1;
        end else if (i_cmd.emit_peak) begin
            r_kind  <= KIND_PEAK;
            r_value <= '0;
            r_tix   <= '0;
            r_oin   <= r_in_peak;
            r_oout  <= r_out_peak;
            r_last  <= 1'b1;
        end else if (i_cmd.tr_load) begin
            r_kind  <= KIND_TRACE;
            r_value <= r_rd;
            r_tix   <= r_tidx;
            r_oin   <= r_in_peak;
            r_oout  <= r_out_peak;
            r_last  <= o_stat.tr_last;
        end
    end

    always_comb begin
        o_stat.clr_last   = r_addr == AW'(HISTORY_DEPTH - 1);
        o_stat.gain_chg   = tgt_clamp != r_latched;
        o_stat.scope      = r_scope;
        o_stat.div_busy   = div_busy;
        o_stat.out_free   = out_free;
        o_stat.srch_first = r_sidx == '0;
        o_stat.srch_hit   = (r_prev <= 0) && (r_rd > 0);
        o_stat.srch_end   = r_sidx == SW'(SEARCH_SPAN - 1);
        o_stat.tr_last    = r_tidx == IDX_W'(TRACE_POINTS - 1);
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_value       = r_value;
    assign o_trace_index = r_tix;
    assign o_in_peak     = r_oin;
    assign o_out_peak    = r_oout;
    assign o_last        = r_last;
endmodule

@@ hw/rtl/grpm_ctrl.sv @@
module grpm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [grpm_pkg::CMD_W-1:0] i_in_cmd,
    input  grpm_pkg::t_dp_stat         i_stat,
    output logic                       o_in_ready,
    output grpm_pkg::t_dp_cmd          o_cmd
);
    import grpm_pkg::*;

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b000000000001,
        ST_IDLE  = 12'b000000000010,
        ST_DIV   = 12'b000000000100,
        ST_MLO   = 12'b000000001000,
        ST_MHI   = 12'b000000010000,
        ST_FIN   = 12'b000000100000,
        ST_EMIT  = 12'b000001000000,
        ST_PEAK  = 12'b000010000000,
        ST_SA    = 12'b000100000000,
        ST_SB    = 12'b001000000000,
        ST_TA    = 12'b010000000000,
        ST_TB    = 12'b100000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_START: begin
                            o_cmd.start_blk = 1'b1;
                            if (i_stat.gain_chg) begin
                                o_cmd.div_start = 1'b1;
                                n_state         = ST_DIV;
                            end
                        end
                        CMD_SAMPLE: begin
                            o_cmd.take_sample = 1'b1;
                            n_state           = ST_MLO;
                        end
                        CMD_END: begin
                            if (i_stat.scope) begin
                                o_cmd.srch_init = 1'b1;
                                n_state         = ST_SA;
                            end else begin
                                n_state = ST_PEAK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_MLO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MHI;
            end
            ST_MHI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_sample = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_PEAK: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_peak = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_SA: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_SB;
            end
            ST_SB: begin
                o_cmd.srch_step = 1'b1;
                if (!i_stat.srch_first && (i_stat.srch_hit || i_stat.srch_end))
                    n_state = ST_TA;
                else
                    n_state = ST_SA;
            end
            ST_TA: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = ST_TB;
            end
            ST_TB: begin
                if (i_stat.out_free) begin
                    o_cmd.tr_load = 1'b1;
                    n_state       = i_stat.tr_last ? ST_IDLE : ST_TA;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready = r_state == ST_IDLE;
endmodule

@@ hw/rtl/gain_ramp_peak_meter_scope.sv @@
// Gain ramp, peak meter and scope trace for interleaved Q1.23 samples.
// One item is worked on at a time; the result register lets the next item
// be taken while a result waits. A sample passes through ST_MLO and ST_MHI
// (two 24x16/24x17 partial products), then ST_FIN and ST_EMIT (sign and
// meter update). A block start that changes the target waits in ST_DIV for
// the bit-serial divider that forms the ramp step. A block end without scope
// gives one summary; with scope, the crossing search reads the history one
// entry per ST_SA/ST_SB pair, up to SEARCH_SPAN entries, and the trace
// reads each point through ST_TA and ST_TB. ST_CLEAR clears the history
// after reset, taking no item; configuration writes are taken at any time.
module gain_ramp_peak_meter_scope #(
    parameter int HISTORY_DEPTH = grpm_pkg::HISTORY_DEPTH_DEF,
    parameter int SEARCH_SPAN   = grpm_pkg::SEARCH_SPAN_DEF,
    parameter int TRACE_POINTS  = grpm_pkg::TRACE_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [grpm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [grpm_pkg::CFG_W-1:0]     i_cfg_data,
    grpm_in_if.sink                        i_in,
    grpm_out_if.source                     o_out
);
    import grpm_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    grpm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .i_stat     (dp_stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (dp_cmd)
    );

    grpm_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SEARCH_SPAN   (SEARCH_SPAN),
        .TRACE_POINTS  (TRACE_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_in.sample_in),
        .i_channel     (i_in.channel),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_kind        (o_out.kind),
        .o_value       (o_out.value),
        .o_trace_index (o_out.trace_index),
        .o_in_peak     (o_out.in_peak),
        .o_out_peak    (o_out.out_peak),
        .o_last        (o_out.last)
    );

`ifndef ASSERT_OFF
    a_sample_no_peaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind == KIND_SAMPLE)
        |-> (o_out.in_peak == '0) && (o_out.out_peak == '0) && o_out.last)
        else $error("sample result carries peaks or lacks last");

    a_trace_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind == KIND_TRACE)
        |-> (o_out.last == (o_out.trace_index == IDX_W'(TRACE_POINTS - 1))))
        else $error("trace last flag does not match index");

    a_no_take_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_stat.div_busy |-> !i_in.ready)
        else $error("input taken while ramp step division runs");
`endif
endmodule

@@ tb/tb_gain_ramp_peak_meter_scope.sv @@
module tb_gain_ramp_peak_meter_scope;
    import grpm_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [CHAN_W-1:0]          channel;
    } t_item;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]           trace_index;
        logic [PEAK_W-1:0]          in_peak;
        logic [PEAK_W-1:0]          out_peak;
        logic                       last;
    } t_result;

    localparam int HIST = HISTORY_DEPTH_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    grpm_in_if  in_ch();
    grpm_out_if out_ch();

    gain_ramp_peak_meter_scope uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    // predictor state
    logic [CCNT_W-1:0]   chan_cnt_reg;
    logic [FRAMES_W-1:0] ramp_frames_reg;
    logic [TGT_W-1:0]    target_reg;
    logic                scope_reg;
    logic [GAIN_W-1:0]   gain_q32;
    logic signed [STEP_W-1:0] step_q32;
    logic [FRAMES_W-1:0] frames_left;
    logic [TGT_W-1:0]    held_target;
    logic [PEAK_W-1:0]   pk_in, pk_out;
    logic signed [SAMPLE_W-1:0] frame_max;
    logic signed [SAMPLE_W-1:0] history [HIST];
    logic [7:0]          hist_wr;

    t_item   pending_items[$];
    t_result expected_results[$];
    int errors = 0;
    int n_results = 0;
    int n_traces = 0;

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [23:0] mag24(logic signed [SAMPLE_W-1:0] v);
        return v < 0 ? 24'(-32'(v)) : 24'(v);
    endfunction

    function automatic logic [PEAK_W-1:0] clip_peak(logic [23:0] m);
        return m > 24'(PEAK_MAX) ? PEAK_MAX : m[PEAK_W-1:0];
    endfunction

    task automatic add_result(logic [KIND_W-1:0] k, logic signed [SAMPLE_W-1:0] v,
                              logic [IDX_W-1:0] ix, logic [PEAK_W-1:0] ip,
                              logic [PEAK_W-1:0] op, logic lst);
        t_result r;
        r.kind = k; r.value = v; r.trace_index = ix;
        r.in_peak = ip; r.out_peak = op; r.last = lst;
        expected_results.push_back(r);
    endtask

    task automatic predict_item(t_item it);
        logic [TGT_W-1:0] tgt;
        logic [16:0] len;
        longint diff;
        int cnt;
        logic [23:0] mx;
        logic [63:0] prod;
        logic signed [SAMPLE_W-1:0] y;
        int start;
        int b, a;
        case (it.cmd)
            CMD_START: begin
                tgt = target_reg > UNITY_Q16 ? UNITY_Q16 : target_reg;
                if (tgt != held_target) begin
                    len = ramp_frames_reg == 0 ? 17'd1 : 17'(ramp_frames_reg);
                    diff = (longint'(tgt) <<< 16) - longint'(gain_q32);
                    held_target = tgt;
                    frames_left = len[FRAMES_W-1:0];
                    step_q32 = STEP_W'(diff / longint'(len));
                end
                pk_in = 0; pk_out = 0; frame_max = 0;
            end
            CMD_SAMPLE: begin
                cnt = chan_cnt_reg == 0 ? 1 : (chan_cnt_reg > MAX_CHANNELS ?
                      MAX_CHANNELS : int'(chan_cnt_reg));
                mx = mag24(it.sample_in);
                if (it.channel == 0 && frames_left != 0) begin
                    gain_q32 = GAIN_W'(longint'(gain_q32) + longint'(step_q32));
                    frames_left = frames_left - 1;
                    if (frames_left == 0) gain_q32 = GAIN_W'(held_target) << 16;
                end
                prod = (64'(mx) * 64'(gain_q32)) >> 32;
                y = it.sample_in < 0 ? -SAMPLE_W'(prod) : SAMPLE_W'(prod);
                if (clip_peak(mx) > pk_in) pk_in = clip_peak(mx);
                if (clip_peak(mag24(y)) > pk_out) pk_out = clip_peak(mag24(y));
                if (scope_reg && mag24(y) > mag24(frame_max)) frame_max = y;
                if (int'(it.channel) + 1 >= cnt) begin
                    if (scope_reg) begin
                        history[hist_wr] = frame_max;
                        hist_wr = hist_wr + 1;
                    end
                    frame_max = 0;
                end
                add_result(KIND_SAMPLE, y, 0, 0, 0, 1'b1);
            end
            CMD_END: begin
                if (!scope_reg) begin
                    add_result(KIND_PEAK, 0, 0, pk_in, pk_out, 1'b1);
                end else begin
                    // first rising zero crossing in the search window
                    start = hist_wr;
                    for (int i = 1; i < SEARCH_SPAN_DEF; i++) begin
                        b = (hist_wr + i - 1) % HIST;
                        a = (hist_wr + i) % HIST;
                        if (history[b] <= 0 && history[a] > 0) begin
                            start = a;
                            break;
                        end
                    end
                    for (int i = 0; i < TRACE_POINTS_DEF; i++)
                        add_result(KIND_TRACE, history[(start + 2 * i) % HIST], IDX_W'(i),
                                   pk_in, pk_out, i == TRACE_POINTS_DEF - 1);
                    n_traces++;
                end
            end
            default: ;
        endcase
    endtask

    // driver
    int in_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap = $urandom_range(0, 4);
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_item(t_item'({in_ch.cmd, in_ch.sample_in, in_ch.channel}));
                in_gap = $urandom_range(0, 4);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0 || pending_items.size() == 0) begin
                    if (in_gap > 0) in_gap--;
                    in_ch.valid <= 1'b0;
                end else begin
                    t_item it;
                    it = pending_items.pop_front();
                    in_ch.valid     <= 1'b1;
                    in_ch.cmd       <= it.cmd;
                    in_ch.sample_in <= it.sample_in;
                    in_ch.channel   <= it.channel;
                end
            end
        end
    end

    // monitor
    int out_stall = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                t_result got, want;
                got = {out_ch.kind, out_ch.value, out_ch.trace_index,
                       out_ch.in_peak, out_ch.out_peak, out_ch.last};
                n_results++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer, got %h", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind)
                        $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                    if (got.value != want.value)
                        $display("%0t: value exp %0d got %0d", $time, want.value, got.value);
                    if (got.trace_index != want.trace_index)
                        $display("%0t: trace_index exp %0d got %0d", $time,
                                 want.trace_index, got.trace_index);
                    if (got.in_peak != want.in_peak)
                        $display("%0t: in_peak exp %0d got %0d", $time,
                                 want.in_peak, got.in_peak);
                    if (got.out_peak != want.out_peak)
                        $display("%0t: out_peak exp %0d got %0d", $time,
                                 want.out_peak, got.out_peak);
                    if (got.last != want.last)
                        $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                    if (got != want) errors++;
                end
                out_stall = $urandom_range(0, 4);
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CHAN_CNT:    chan_cnt_reg    = CCNT_W'(val);
            CFG_RAMP_FRAMES: ramp_frames_reg = FRAMES_W'(val);
            CFG_TARGET_GAIN: target_reg      = TGT_W'(val);
            default:         scope_reg       = 1'(val);
        endcase
    endtask

    task automatic queue_item(logic [CMD_W-1:0] c, int s, int ch);
        t_item it;
        it.cmd = c; it.sample_in = SAMPLE_W'(s); it.channel = CHAN_W'(ch);
        pending_items.push_back(it);
    endtask

    // wait until everything queued is sent and answered, plus the block-start divider
    task automatic drain;
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 5))
            0: return 8388607;
            1: return -8388608;
            2: return $urandom_range(0, 200) - 100;
            default: return int'($urandom) >>> 8;
        endcase
    endfunction

    // one block: start, some frames of samples, sometimes an unused command, end
    task automatic queue_block(int chans, int frames);
        queue_item(CMD_START, 0, 0);
        for (int f = 0; f < frames; f++)
            for (int c = 0; c < chans; c++)
                queue_item(CMD_SAMPLE, rand_sample(), c);
        if ($urandom_range(0, 9) == 0) queue_item(CMD_UNUSED, rand_sample(), 0);
        queue_item(CMD_END, rand_sample(), $urandom_range(0, 31));
    endtask

    initial begin
        int chans;
        i_rst_n = 0;
        i_cfg_we = 0; i_cfg_idx = '0; i_cfg_data = '0;
        in_ch.valid = 0; in_ch.cmd = '0; in_ch.sample_in = '0; in_ch.channel = '0;
        out_ch.ready = 0;
        chan_cnt_reg = CHAN_CNT_RST; ramp_frames_reg = RAMP_FRAMES_RST;
        target_reg = UNITY_Q16; scope_reg = 0;
        gain_q32 = GAIN_W'(UNITY_Q16) << 16; step_q32 = 0; frames_left = 0;
        held_target = UNITY_Q16; pk_in = 0; pk_out = 0; frame_max = 0; hist_wr = 0;
        for (int i = 0; i < HIST; i++) history[i] = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at unity, a ramp to zero, target above unity, odd channel counts
        queue_item(CMD_START, 0, 0);
        queue_item(CMD_SAMPLE, 8388607, 0);
        queue_item(CMD_SAMPLE, -8388608, 1);
        queue_item(CMD_SAMPLE, -1, 31);
        queue_item(CMD_UNUSED, 5, 3);
        queue_item(CMD_END, 0, 0);
        drain();
        cfg_write(CFG_RAMP_FRAMES, 0);
        cfg_write(CFG_TARGET_GAIN, 0);
        cfg_write(CFG_CHAN_CNT, 0);
        queue_item(CMD_START, 0, 0);
        queue_item(CMD_SAMPLE, 8388607, 0);
        queue_item(CMD_SAMPLE, -8388608, 0);
        queue_item(CMD_END, 0, 0);
        drain();
        cfg_write(CFG_TARGET_GAIN, 131071);
        cfg_write(CFG_RAMP_FRAMES, 3);
        cfg_write(CFG_CHAN_CNT, 63);
        cfg_write(CFG_SCOPE_EN, 1);
        queue_item(CMD_START, 0, 0);
        for (int i = 0; i < 4; i++) queue_item(CMD_SAMPLE, (i % 2) ? 4000000 : -4000000, 0);
        queue_item(CMD_SAMPLE, 1234, 31);
        queue_item(CMD_END, 0, 0);
        drain();

        // random blocks through several settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: chans = 1;
                1: chans = 32;
                default: chans = $urandom_range(1, 6);
            endcase
            cfg_write(CFG_CHAN_CNT, chans);
            cfg_write(CFG_RAMP_FRAMES, phase == 2 ? 65535 : $urandom_range(1, 8));
            cfg_write(CFG_TARGET_GAIN, phase == 3 ? 65536 : $urandom_range(0, 70000));
            cfg_write(CFG_SCOPE_EN, phase % 2);
            for (int b = 0; b < 3; b++)
                queue_block(chans, chans > 8 ? 1 : $urandom_range(2, 14 / chans + 2));
            drain();
        end
        $display("covered %0d results, %0d scope traces, channel counts 0 to 63",
                 n_results, n_traces);
        if (errors == 0) begin
            $display("tb_gain_ramp_peak_meter_scope: clean");
        end else begin
            $display("tb_gain_ramp_peak_meter_scope: errors");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb_gain_ramp_peak_meter_scope: errors");
        $finish;
    end
endmodule
